FILE: hdl/gpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_pkg
// shared types and constants of the gait phase generator
// ----------------------------------------------------------------------------
package gpg_pkg;

    localparam logic [1:0] MODE_WAVE    = 2'd0;
    localparam logic [1:0] MODE_SWING   = 2'd1;
    localparam logic [1:0] MODE_STANCE  = 2'd2;
    localparam logic [1:0] MODE_RSVD    = 2'd3;

    localparam logic [2:0] REG_PERIOD   = 3'd0;
    localparam logic [2:0] REG_STANCE   = 3'd1;
    localparam logic [2:0] REG_BIAS0    = 3'd2;
    localparam logic [2:0] REG_START    = 3'd6;

    localparam int PERIOD_W = 24;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;
    localparam int MAX_BIAS_REGS = 4;

    typedef struct packed {
        logic start;
        logic wave;
    } lane_ctl_t;

endpackage

FILE: hdl/gait_phase_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gait_phase_generator
// four-leg wave gait phase generator with held mode transitions
// ----------------------------------------------------------------------------
// an accepted item is worked by the bit-serial remainder and phase divider in
// each leg lane; no new item is taken until all lanes finish, and the result
// is held back only while a finished result waits on out_stall; a new item is
// taken while a result waits
// reset: config registers to defaults, settled mode all swing, no pending transition
module gait_phase_generator
    import gpg_pkg::*;
#(
    parameter int LEGS       = 4,
    parameter int PHASE_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [TIME_W-1:0]       now_us,
    input  logic [1:0]              mode,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [LEGS-1:0]         stance_mask,
    output logic [PHASE_BITS-1:0]   phase_leg0,
    output logic [PHASE_BITS-1:0]   phase_leg1,
    output logic [PHASE_BITS-1:0]   phase_leg2,
    output logic [PHASE_BITS-1:0]   phase_leg3,
    output logic                    in_transition
);

    localparam logic [PHASE_BITS-1:0] HALF = PHASE_BITS'(1) << (PHASE_BITS - 1);

    logic [PERIOD_W-1:0]            period_reg;
    logic [PHASE_BITS-1:0]          ratio_reg;
    logic [LEGS-1:0][PHASE_BITS:0]  bias_reg;
    logic [TIME_W-1:0]              start_reg;

    logic                           busy_reg, launch_reg, ov_reg;
    logic [1:0]                     req_reg;
    logic [TIME_W-1:0]              el_reg;
    logic [1:0]                     settled, m_eff;
    logic                           acc, go, all_done;
    lane_ctl_t                      ctl;
    logic [LEGS-1:0]                dn, st;
    logic [LEGS-1:0][PHASE_BITS-1:0] lph, mph;
    logic [LEGS-1:0]                mmask;
    logic                           mtrans;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_W'(1000000);
            ratio_reg  <= HALF;
            bias_reg   <= '0;
            start_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PERIOD)
                period_reg <= cfg_data[PERIOD_W-1:0];
            else if (cfg_index == REG_STANCE)
                ratio_reg <= cfg_data[PHASE_BITS-1:0];
            else if (cfg_index == REG_START)
                start_reg <= cfg_data;
            else
            begin
                for (int i = 0; i < LEGS && i < MAX_BIAS_REGS; i++)
                    if (cfg_index == REG_BIAS0 + IDX_W'(i))
                        bias_reg[i] <= cfg_data[PHASE_BITS:0];
            end
        end
    end

    assign m_eff    = (mode == MODE_RSVD) ? settled : mode;
    assign in_stall = busy_reg;
    assign acc      = in_valid && !busy_reg;
    assign all_done = &dn;
    assign go       = busy_reg && !launch_reg && all_done && (!ov_reg || !out_stall);
    assign ctl.start = launch_reg;
    assign ctl.wave  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            launch_reg <= acc;
            if (acc)
                busy_reg <= 1'b1;
            else if (go)
                busy_reg <= 1'b0;
            if (go)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            req_reg <= m_eff;
            el_reg  <= now_us - start_reg;
        end
    end

    for (genvar g = 0; g < LEGS; g++)
    begin : g_lane
        gpg_lane #(.PHASE_BITS(PHASE_BITS)) u_lane
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .period  (period_reg),
            .ratio   (ratio_reg),
            .bias    (bias_reg[g]),
            .elapsed (el_reg),
            .done    (dn[g]),
            .stance  (st[g]),
            .phase   (lph[g])
        );
    end

    gpg_merge #(.LEGS(LEGS), .PHASE_BITS(PHASE_BITS)) u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .req       (req_reg),
        .wave_mask (st),
        .wave_ph   (lph),
        .settled   (settled),
        .mask      (mmask),
        .ph        (mph),
        .trans     (mtrans)
    );

    assign out_valid     = ov_reg;
    assign stance_mask   = mmask;
    assign phase_leg0    = mph[0];
    assign phase_leg1    = (LEGS > 1) ? mph[(LEGS > 1) ? 1 : 0] : '0;
    assign phase_leg2    = (LEGS > 2) ? mph[(LEGS > 2) ? 2 : 0] : '0;
    assign phase_leg3    = (LEGS > 3) ? mph[(LEGS > 3) ? 3 : 0] : '0;
    assign in_transition = mtrans;

endmodule

FILE: hdl/gpg_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_lane
// one leg: bit-serial remainder of elapsed time, cycle position, stance test
// and bit-serial phase division
// ----------------------------------------------------------------------------
module gpg_lane
    import gpg_pkg::*;
#(
    parameter int PHASE_BITS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  lane_ctl_t                          ctl,
    input  logic [PERIOD_W-1:0]                period,
    input  logic [PHASE_BITS-1:0]              ratio,
    input  logic [PHASE_BITS:0]                bias,
    input  logic [TIME_W-1:0]                  elapsed,
    output logic                               done,
    output logic                               stance,
    output logic [PHASE_BITS-1:0]              phase
);

    localparam int NW  = PERIOD_W + PHASE_BITS + 1;
    localparam int CW  = $clog2(PHASE_BITS + 4);
    localparam int MW  = $clog2(TIME_W);
    localparam logic [CW-1:0] LAST = CW'(PHASE_BITS + 2);
    localparam logic [MW-1:0] MLAST = MW'(TIME_W - 1);
    localparam logic [PHASE_BITS:0] ONE = (PHASE_BITS+1)'(1) << PHASE_BITS;

    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   mod_reg, mod_next;
    logic [MW-1:0]          mcnt_reg, mcnt_next;
    logic [TIME_W-1:0]      ebits_reg, ebits_next;
    logic [PERIOD_W-1:0]    rem_reg, rem_next;
    logic [NW-1:0]          num_reg, num_next;
    logic [NW-1:0]          cyc_reg, cyc_next;
    logic [NW-1:0]          den_reg, den_next;
    logic [NW-1:0]          sthr_reg, sthr_next;
    logic [PHASE_BITS-1:0]  q_reg, q_next;
    logic                   st_reg, st_next;
    logic [PERIOD_W-1:0]    p;
    logic [PHASE_BITS:0]    b;
    logic [NW:0]            r2;
    logic [PERIOD_W:0]      rm2;
    logic [PERIOD_W-1:0]    rem_step;

    assign p = (period == '0) ? PERIOD_W'(1) : period;
    assign b = (bias > ONE) ? ONE : bias;
    assign r2 = {num_reg, 1'b0};
    assign rm2 = {rem_reg, ebits_reg[TIME_W-1]};
    assign rem_step = (rm2 >= {1'b0, p}) ? PERIOD_W'(rm2 - {1'b0, p}) : PERIOD_W'(rm2);

    always_comb
    begin
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        mod_next   = mod_reg;
        mcnt_next  = mcnt_reg;
        ebits_next = ebits_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        cyc_next   = cyc_reg;
        den_next   = den_reg;
        sthr_next  = sthr_reg;
        q_next     = q_reg;
        st_next    = st_reg;
        if (ctl.start && ctl.wave)
        begin
            mod_next   = 1'b1;
            mcnt_next  = '0;
            rem_next   = '0;
            ebits_next = elapsed;
            cyc_next   = NW'(p) << PHASE_BITS;
            sthr_next  = NW'(p) * NW'(ratio);
            den_next   = NW'(p) * NW'(b);
        end
        else if (mod_reg)
        begin
            // elapsed mod p first keeps the numerator narrow
            mcnt_next  = mcnt_reg + 1'b1;
            ebits_next = ebits_reg << 1;
            rem_next   = rem_step;
            if (mcnt_reg == MLAST)
            begin
                mod_next  = 1'b0;
                busy_next = 1'b1;
                cnt_next  = '0;
                num_next  = NW'(rem_step);
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            unique case (cnt_reg)
                CW'(0):
                begin
                    num_next = (num_reg << PHASE_BITS) + cyc_reg - den_reg;
                end
                CW'(1):
                begin
                    if (num_reg >= cyc_reg)
                        num_next = num_reg - cyc_reg;
                    q_next = '0;
                end
                CW'(2):
                begin
                    if (num_reg < sthr_reg)
                    begin
                        st_next  = 1'b1;
                        den_next = sthr_reg;
                    end
                    else
                    begin
                        st_next  = 1'b0;
                        num_next = num_reg - sthr_reg;
                        den_next = cyc_reg - sthr_reg;
                    end
                end
                default:
                begin
                    if (r2 >= {1'b0, den_reg})
                    begin
                        num_next = NW'(r2 - {1'b0, den_reg});
                        q_next   = {q_reg[PHASE_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        num_next = NW'(r2);
                        q_next   = {q_reg[PHASE_BITS-2:0], 1'b0};
                    end
                    if (cnt_reg == LAST)
                        busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            mod_reg  <= 1'b0;
            mcnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            mod_reg  <= mod_next;
            mcnt_reg <= mcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ebits_reg <= ebits_next;
        rem_reg   <= rem_next;
        num_reg   <= num_next;
        cyc_reg   <= cyc_next;
        den_reg   <= den_next;
        sthr_reg  <= sthr_next;
        q_reg     <= q_next;
        st_reg    <= st_next;
    end

    assign done   = !busy_reg && !mod_reg;
    assign stance = st_reg;
    assign phase  = q_reg;

endmodule

FILE: hdl/gpg_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_merge
// combines lane results with the mode transition state
// ----------------------------------------------------------------------------
module gpg_merge
    import gpg_pkg::*;
#(
    parameter int LEGS       = 4,
    parameter int PHASE_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                go,
    input  logic [1:0]                          req,
    input  logic [LEGS-1:0]                     wave_mask,
    input  logic [LEGS-1:0][PHASE_BITS-1:0]     wave_ph,
    output logic [1:0]                          settled,
    output logic [LEGS-1:0]                     mask,
    output logic [LEGS-1:0][PHASE_BITS-1:0]     ph,
    output logic                                trans
);

    localparam logic [PHASE_BITS-1:0] HALF = PHASE_BITS'(1) << (PHASE_BITS - 1);

    logic [LEGS-1:0]                    pend_reg, pend_next;
    logic [1:0]                         set_reg, set_next;
    logic [LEGS-1:0]                    om_reg, om_next;
    logic [LEGS-1:0][PHASE_BITS-1:0]    oph_reg, oph_next;
    logic [LEGS-1:0]                    nm, m_next;
    logic [LEGS-1:0][PHASE_BITS-1:0]    nph, p_next;
    logic [LEGS-1:0]                    mask_reg;
    logic [LEGS-1:0][PHASE_BITS-1:0]    ph_reg;
    logic                               trans_reg;

    always_comb
    begin
        if (req == MODE_WAVE)
        begin
            nm  = wave_mask;
            nph = wave_ph;
        end
        else
        begin
            nm  = (req == MODE_STANCE) ? '1 : '0;
            nph = {LEGS{HALF}};
        end
        pend_next = pend_reg;
        set_next  = set_reg;
        om_next   = om_reg;
        oph_next  = oph_reg;
        if (req != set_reg)
        begin
            if (pend_reg == '0)
                pend_next = '1;
            if (set_reg == MODE_WAVE)
            begin
                om_next  = wave_mask;
                oph_next = wave_ph;
            end
            else
            begin
                om_next  = (set_reg == MODE_STANCE) ? '1 : '0;
                oph_next = {LEGS{HALF}};
            end
            if (req == MODE_SWING && set_reg == MODE_STANCE)
                om_next = '0;
            else if (req == MODE_STANCE && set_reg == MODE_SWING)
                om_next = '1;
        end
        m_next = nm;
        p_next = nph;
        if (pend_next != '0)
        begin
            for (int i = 0; i < LEGS; i++)
            begin
                if (nm[i] == om_next[i])
                    pend_next[i] = 1'b0;
                else
                begin
                    m_next[i] = om_next[i];
                    p_next[i] = oph_next[i];
                end
            end
            if (pend_next == '0)
                set_next = req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            set_reg  <= MODE_SWING;
            om_reg   <= '0;
            oph_reg  <= {LEGS{HALF}};
        end
        else if (go)
        begin
            pend_reg <= pend_next;
            set_reg  <= set_next;
            om_reg   <= om_next;
            oph_reg  <= oph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            mask_reg  <= m_next;
            ph_reg    <= p_next;
            trans_reg <= (pend_next != '0);
        end
    end

    assign settled = set_reg;
    assign mask    = mask_reg;
    assign ph      = ph_reg;
    assign trans   = trans_reg;

endmodule

FILE: hdl/gpg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_checker
// port-level checks of the gait phase generator
// ----------------------------------------------------------------------------
module gpg_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  stance_mask,
    input  logic        in_transition
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(stance_mask))
        else $error("result dropped under stall");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while working");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result one cycle after accept");

    a_trans_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(in_transition))
        else $error("transition flag changed under stall");

endmodule

bind gait_phase_generator gpg_checker u_gpg_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .stance_mask   (stance_mask),
    .in_transition (in_transition)
);
